FILE: rtl/core/eem_pkg.sv
// ----------------------------------------------------------------------------
// eem_pkg
// Shared types and constants of the energy efficiency meter.
// ----------------------------------------------------------------------------
`default_nettype none

package eem_pkg;

  localparam logic [1:0] FUNC_SAMPLE  = 2'd0;
  localparam logic [1:0] FUNC_CHG_ON  = 2'd1;
  localparam logic [1:0] FUNC_CHG_OFF = 2'd2;
  localparam logic [1:0] FUNC_RESET   = 2'd3;

  localparam logic REG_FINAL_DRIVE = 1'b0;
  localparam logic REG_WHEEL       = 1'b1;

  localparam logic [12:0] FINAL_DRIVE_RST = 13'd2304;
  localparam logic [11:0] WHEEL_RST       = 12'd2000;

  localparam int ENTRY_E_W = 36;
  localparam int ENTRY_D_W = 27;

  localparam int DIV_N_W   = 64;
  localparam int DIV_D_W   = 48;
  localparam int DIV_CNT_W = 6;

  localparam logic [31:0] MIN_GAP_MS = 32'd500;
  localparam logic [31:0] MAX_DT_MS  = 32'd65535;

  localparam logic [63:0] DIST_ENTRY_MAX = 64'd134217727;
  localparam logic [63:0] WHKM_MAX       = 64'd549755813887;
  localparam logic [63:0] KMKWH_MAX      = 64'd1000000000;
  localparam logic [47:0] CHG_E_MAX      = 48'd140737488355327;
  localparam logic [40:0] SESS_D_MAX     = 41'd1099511627775;

  localparam logic [63:0] K_WHKM  = 64'd2500;
  localparam logic [47:0] K_NINE  = 48'd9;
  localparam logic [63:0] K_KMKWH = 64'd3600000;
  localparam logic [28:0] K_RPM   = 29'd60000;
  localparam logic [9:0]  K_MIN_D = 10'd1000;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/eem_divider.sv
// ----------------------------------------------------------------------------
// eem_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module eem_divider (
  input  wire                   clk,
  input  wire                   rst,
  input  eem_pkg::div_req_t     req,
  output eem_pkg::div_rsp_t     rsp
);

  logic [eem_pkg::DIV_D_W-1:0]   rem;
  logic [eem_pkg::DIV_N_W-1:0]   quo;
  logic [eem_pkg::DIV_D_W-1:0]   dvs;
  logic [eem_pkg::DIV_CNT_W-1:0] cnt;
  logic                          busy;
  logic                          done;
  logic [eem_pkg::DIV_D_W:0]     trial;
  logic                          fits;

  assign trial = {rem, quo[eem_pkg::DIV_N_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == eem_pkg::DIV_CNT_W'(eem_pkg::DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= fits ? eem_pkg::DIV_D_W'(trial - {1'b0, dvs}) : trial[eem_pkg::DIV_D_W-1:0];
      quo <= {quo[eem_pkg::DIV_N_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

FILE: rtl/core/ev_energy_efficiency_meter.sv
// ----------------------------------------------------------------------------
// ev_energy_efficiency_meter
// Windowed and session energy / distance metering with efficiency ratios.
//
//   channel | dir | handshake        | payload
//   s_      | in  | s_tvalid/tready  | s_tuser func, s_tdata sample
//   m_      | out | m_tvalid/tready  | m_tdata result word
//   apb     | in  | psel/penable     | paddr, pwdata, prdata
//
// A sample word passes from acceptance to the result word through up to
// three passes of the shared divider (distance, Wh/km, km/kWh) and the
// sequencer steps around them; skipped passes shorten it.
// A command word skips the distance pass. s_tready is high only when idle.
// rst is synchronous; evicted entries are zero until the window fills once.
// A finished word waits in the output register while m_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module ev_energy_efficiency_meter #(
  parameter int WINDOW_DEPTH = 64
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [71:0]  s_tdata,   // now_ms[31:0], power_w[51:32], speed_rpm[67:52]
  input  wire  [1:0]   s_tuser,   // func[1:0]
  output logic         m_tvalid,
  input  wire          m_tready,
  // sample_taken[0], wh_per_km_milli[40:1], wh_per_km_valid[41],
  // km_per_kwh_milli[71:42], km_per_kwh_valid[72], session_energy_mj[120:73],
  // session_distance_mm[160:121], charge_energy_mj[207:161], charging_active[208]
  output logic [215:0] m_tdata,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [2:0]   paddr,
  input  wire  [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int IDX_W  = $clog2(WINDOW_DEPTH);
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int ESUM_W = eem_pkg::ENTRY_E_W + IDX_W;
  localparam int DSUM_W = eem_pkg::ENTRY_D_W + IDX_W;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_MUL1  = 12'b000000000010,
    S_MUL2  = 12'b000000000100,
    S_DIST  = 12'b000000001000,
    S_DISTW = 12'b000000010000,
    S_UPD   = 12'b000000100000,
    S_RAT   = 12'b000001000000,
    S_WDIV  = 12'b000010000000,
    S_WWAIT = 12'b000100000000,
    S_KDIV  = 12'b001000000000,
    S_KWAIT = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state;

  logic [12:0] final_drive;
  logic [11:0] wheel;

  logic               [1:0]  in_func;
  logic signed        [19:0] in_pw;
  logic               [14:0] rpm_pos;
  logic               [15:0] dtc;
  logic                      taken;
  logic               [31:0] last_ms;
  logic               [31:0] dt;
  logic                      accept;

  logic               [26:0] p1;
  logic               [42:0] num;
  logic signed        [36:0] energy_p;
  logic               [26:0] dist_mm;

  logic signed [eem_pkg::ENTRY_E_W-1:0] mem_e [WINDOW_DEPTH];
  logic        [eem_pkg::ENTRY_D_W-1:0] mem_d [WINDOW_DEPTH];
  logic signed [eem_pkg::ENTRY_E_W-1:0] old_e;
  logic        [eem_pkg::ENTRY_D_W-1:0] old_d;
  logic signed [eem_pkg::ENTRY_E_W-1:0] old_e_m;
  logic        [eem_pkg::ENTRY_D_W-1:0] old_d_m;
  logic signed [eem_pkg::ENTRY_E_W-1:0] energy;
  logic                                 full;

  logic signed [ESUM_W-1:0] esum;
  logic        [DSUM_W-1:0] dsum;
  logic        [IDX_W-1:0]  wpos;
  logic        [FILL_W-1:0] fill;

  logic signed [47:0] sess_e;
  logic        [39:0] sess_d;
  logic        [46:0] chg_e;
  logic               chg_open;
  logic signed [48:0] sess_e_sum;
  logic        [40:0] sess_d_sum;
  logic        [47:0] chg_sum;

  logic        [ESUM_W-1:0] eabs;
  logic        [63:0] prod_w;
  logic        [63:0] prod_k;
  logic        [47:0] dvs_w;
  logic               wh_ok;
  logic               wh_valid;
  logic               esum_neg;
  logic               esum_pos;
  logic signed [39:0] whkm;
  logic        [29:0] kmkwh;

  eem_pkg::div_req_t div_req;
  eem_pkg::div_rsp_t div_rsp;

  eem_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      final_drive <= eem_pkg::FINAL_DRIVE_RST;
      wheel       <= eem_pkg::WHEEL_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        eem_pkg::REG_FINAL_DRIVE: final_drive <= pwdata[12:0];
        eem_pkg::REG_WHEEL:       wheel       <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      eem_pkg::REG_FINAL_DRIVE: prdata = {19'd0, final_drive};
      eem_pkg::REG_WHEEL:       prdata = {20'd0, wheel};
      default:                  prdata = '0;
    endcase
  end

  assign s_tready = state == S_IDLE;
  assign accept   = s_tvalid && s_tready;
  assign dt       = s_tdata[31:0] - last_ms;

  assign full    = fill == FILL_W'(WINDOW_DEPTH);
  assign old_e_m = full ? old_e : '0;
  assign old_d_m = full ? old_d : '0;
  assign energy  = energy_p[eem_pkg::ENTRY_E_W-1:0];

  assign sess_e_sum = {sess_e[47], sess_e} + 49'(energy);
  assign sess_d_sum = {1'b0, sess_d} + 41'(dist_mm);
  assign chg_sum    = {1'b0, chg_e} + 48'(36'(-energy));

  assign esum_neg = esum < 0;
  assign esum_pos = esum > 0;
  assign eabs     = esum_neg ? ESUM_W'(-esum) : ESUM_W'(esum);
  assign wh_ok    = fill >= FILL_W'(3) && dsum >= DSUM_W'(eem_pkg::K_MIN_D);

  // window memories
  always_ff @(posedge clk) begin
    if (state == S_UPD && taken) begin
      mem_e[wpos] <= energy;
      mem_d[wpos] <= dist_mm;
    end
    old_e <= mem_e[wpos];
    old_d <= mem_d[wpos];
  end

  function automatic logic [28:0] K_RPM_MUL(input logic [12:0] fd);
    K_RPM_MUL = eem_pkg::K_RPM * 29'(fd);
  endfunction

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state)
      S_DIST: begin
        div_req.start    = 1'b1;
        div_req.dividend = {13'd0, num, 8'd0};
        div_req.divisor  = 48'(K_RPM_MUL(final_drive));
      end
      S_WDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_w;
        div_req.divisor  = dvs_w;
      end
      S_KDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_k;
        div_req.divisor  = 48'(eabs);
      end
      default: ;
    endcase
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      last_ms  <= '0;
      esum     <= '0;
      dsum     <= '0;
      wpos     <= '0;
      fill     <= '0;
      sess_e   <= '0;
      sess_d   <= '0;
      chg_e    <= '0;
      chg_open <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (s_tuser == eem_pkg::FUNC_SAMPLE && dt >= eem_pkg::MIN_GAP_MS) begin
              last_ms <= s_tdata[31:0];
              state   <= S_MUL1;
            end else begin
              state <= S_UPD;
            end
          end
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: begin
          if (rpm_pos == '0 || final_drive == '0) state <= S_UPD;
          else state <= S_DIST;
        end
        S_DIST: state <= S_DISTW;
        S_DISTW: if (div_rsp.done) state <= S_UPD;
        S_UPD: begin
          state <= S_RAT;
          if (taken) begin
            esum <= esum + ESUM_W'(energy) - ESUM_W'(old_e_m);
            dsum <= dsum + DSUM_W'(dist_mm) - DSUM_W'(old_d_m);
            wpos <= (wpos == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : wpos + 1'b1;
            if (!full) fill <= fill + 1'b1;
            if (sess_e_sum[48] != sess_e_sum[47])
              sess_e <= sess_e_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
            else
              sess_e <= sess_e_sum[47:0];
            sess_d <= sess_d_sum > eem_pkg::SESS_D_MAX ? 40'(eem_pkg::SESS_D_MAX)
                                                       : sess_d_sum[39:0];
            if (chg_open && in_pw < 0)
              chg_e <= chg_sum > eem_pkg::CHG_E_MAX ? 47'(eem_pkg::CHG_E_MAX)
                                                    : chg_sum[46:0];
          end else begin
            unique case (in_func)
              eem_pkg::FUNC_CHG_ON: begin
                chg_open <= 1'b1;
                chg_e    <= '0;
              end
              eem_pkg::FUNC_CHG_OFF: chg_open <= 1'b0;
              eem_pkg::FUNC_RESET: begin
                sess_e <= '0;
                sess_d <= '0;
                chg_e  <= '0;
              end
              default: ;
            endcase
          end
        end
        S_RAT: state <= wh_ok ? S_WDIV : S_OUT;
        S_WDIV: state <= S_WWAIT;
        S_WWAIT: if (div_rsp.done) state <= esum_pos ? S_KDIV : S_OUT;
        S_KDIV: state <= S_KWAIT;
        S_KWAIT: if (div_rsp.done) state <= S_OUT;
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          in_func <= s_tuser;
          in_pw   <= s_tdata[51:32];
          rpm_pos <= s_tdata[67] ? '0 : s_tdata[66:52];
          dtc     <= dt > eem_pkg::MAX_DT_MS ? 16'hFFFF : dt[15:0];
          taken   <= s_tuser == eem_pkg::FUNC_SAMPLE && dt >= eem_pkg::MIN_GAP_MS;
        end
      end
      S_MUL1: begin
        p1       <= 27'(rpm_pos) * 27'(wheel);
        energy_p <= in_pw * $signed({1'b0, dtc});
        dist_mm  <= '0;
      end
      S_MUL2: num <= 43'(p1) * 43'(dtc);
      S_DISTW: begin
        if (div_rsp.done)
          dist_mm <= div_rsp.quotient > eem_pkg::DIST_ENTRY_MAX ? '1
                                                                : div_rsp.quotient[26:0];
      end
      S_RAT: begin
        wh_valid <= wh_ok;
        prod_w   <= 64'(eabs) * eem_pkg::K_WHKM;
        prod_k   <= 64'(dsum) * eem_pkg::K_KMKWH;
        dvs_w    <= 48'(dsum) * eem_pkg::K_NINE;
        whkm     <= '0;
        kmkwh    <= '0;
      end
      S_WWAIT: begin
        if (div_rsp.done) begin
          if (esum_neg)
            whkm <= div_rsp.quotient > eem_pkg::WHKM_MAX + 64'd1 ? {1'b1, 39'd0}
                                                                 : 40'(-div_rsp.quotient);
          else
            whkm <= div_rsp.quotient > eem_pkg::WHKM_MAX ? {1'b0, {39{1'b1}}}
                                                         : div_rsp.quotient[39:0];
        end
      end
      S_KWAIT: begin
        if (div_rsp.done)
          kmkwh <= div_rsp.quotient > eem_pkg::KMKWH_MAX ? 30'(eem_pkg::KMKWH_MAX)
                                                         : div_rsp.quotient[29:0];
      end
      S_OUT: begin
        if (!m_tvalid || m_tready)
          m_tdata <= {7'd0, chg_open, chg_e, sess_d, sess_e,
                      wh_valid && esum_pos, kmkwh, wh_valid, whkm, taken};
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
